// ----- rtl/zbke_pkg.sv -----
// ----------------------------------------------------------------------------
// zbke_pkg
// Shared types, Q15.32 constants, unit latencies and the sign/saturate helper
// used by the multiply and divide units.
// ----------------------------------------------------------------------------
package zbke_pkg;

    typedef struct packed {
        logic              flt;
        logic signed [47:0] val;
    } zq_t;

    localparam logic signed [47:0] QMAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] QMIN = 48'sh8000_0000_0000;

    // Q15.32 constants, round to nearest of value * 2^32
    localparam logic signed [47:0] K_W      = 48'sd26986052615;
    localparam logic signed [47:0] K_OOEPS1 = 48'sd39045157236;
    localparam logic signed [47:0] K_GE2    = 48'sd87617;
    localparam logic signed [47:0] K_INV4G  = 48'sd52634403137255;
    localparam logic signed [47:0] K_16G    = 48'sd1401877;
    localparam logic signed [47:0] K_EPS31  = 48'sd4301839244;
    localparam logic signed [47:0] K_ALPHA  = 48'sd429496730;
    localparam logic signed [47:0] K_BETA   = 48'sd73014;
    localparam logic signed [47:0] K_MU     = 48'sd1030792;
    localparam logic signed [47:0] K_Q      = 48'sd3006477107;
    localparam logic signed [47:0] K_PHI    = 48'sd2254858;
    localparam logic signed [47:0] K_2PHI   = 48'sd4509716;
    localparam logic signed [47:0] K_ONE    = 48'sd4294967296;

    localparam logic [1:0] MODEL_PHASE_FIXED = 2'd0;
    localparam logic [1:0] MODEL_PHASE_CELL  = 2'd1;
    localparam logic [1:0] MODEL_ZBKE        = 2'd2;
    localparam logic [1:0] MODEL_ZBKE_CELL   = 2'd3;

    localparam logic REG_MODEL_SELECT = 1'b0;
    localparam logic REG_STEP_SIZE    = 1'b1;

    localparam int MUL_LAT  = 4;
    localparam int DIV_LAT  = 83;
    localparam int SQRT_LAT = 41;

    // apply sign to a magnitude, clamp to the Q15.32 range
    function automatic zq_t sat_mag(input logic neg, input logic [50:0] m, input logic big);
        zq_t        r;
        logic [50:0] lim;
        lim = neg ? 51'h0_8000_0000_0000 : 51'h0_7FFF_FFFF_FFFF;
        if (big || (m > lim)) begin
            r.flt = 1'b1;
            r.val = neg ? QMIN : QMAX;
        end else begin
            r.flt = 1'b0;
            r.val = neg ? 48'(51'd0 - m) : m[47:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/zbke_reaction_euler_step_core.sv -----
// ----------------------------------------------------------------------------
// zbke_reaction_euler_step_core
// One forward Euler step of a phase oscillator or the ZBKE model per cell,
// signed Q15.32, saturating, with a range fault flag.
// ----------------------------------------------------------------------------
// Takes one cell every clock cycle (busy is never raised) and returns its
// result with done high. The pipeline depth is set by the
// ZBKE path: a multiply, an 80-stage bit-per-stage divider, four further
// multiplies and the adds between them in series. Results are shown for one
// cycle only and must be taken then. model_select and step_size are read live,
// so write them only when no transaction is in flight.
// ----------------------------------------------------------------------------
module zbke_reaction_euler_step_core import zbke_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               cfg_we,
    input  logic [0:0]         cfg_addr,
    input  logic [46:0]        cfg_wdata,
    input  logic signed [47:0] u_now,
    input  logic signed [47:0] v_now,
    input  logic signed [47:0] het_value,
    output logic               done,
    output logic signed [47:0] u_next,
    output logic signed [47:0] v_next,
    output logic               range_fault
);

    // schedule: cycle at which each registered value is available
    localparam int T_W     = 1;
    localparam int T_UU    = MUL_LAT;
    localparam int T_16GU  = MUL_LAT;
    localparam int T_AV    = MUL_LAT;
    localparam int T_D1    = 1;
    localparam int T_N2    = 1;
    localparam int T_WW    = T_W + MUL_LAT;
    localparam int T_DISC  = T_WW + 1;
    localparam int T_SQ    = T_DISC + SQRT_LAT;
    localparam int T_SW    = T_SQ + 1;
    localparam int T_USS   = T_SW + MUL_LAT;
    localparam int T_USSW  = T_USS + MUL_LAT;
    localparam int T_GU    = T_USS + MUL_LAT;
    localparam int T_GU2   = T_GU + MUL_LAT;
    localparam int T_RATIO = T_N2 + DIV_LAT;
    localparam int T_TEMP  = T_AV + DIV_LAT;
    localparam int T_QT    = T_TEMP + MUL_LAT;
    localparam int T_INNER = T_QT + 1;
    localparam int T_RI    = T_INNER + MUL_LAT;
    localparam int T_F1    = T_UU + 1;
    localparam int T_F2    = T_F1 + 1;
    localparam int T_F3    = T_GU2 + 1;
    localparam int T_F4    = T_F3 + 1;
    localparam int T_F5    = T_RI + 1;
    localparam int T_OF    = T_F5 + MUL_LAT;
    localparam int T_UM    = T_OF + MUL_LAT;
    localparam int T_UN    = T_UM + 1;
    localparam int T_A1    = T_USSW + 1;
    localparam int T_A2    = T_TEMP + 1;
    localparam int T_VM    = T_A2 + MUL_LAT;
    localparam int T_VN    = T_VM + 1;
    localparam int T_P1    = MUL_LAT;
    localparam int T_P2    = T_P1 + 1;

    function automatic zq_t sat_add(input logic signed [47:0] a, input logic signed [47:0] b,
                                    input logic sub);
        logic signed [48:0] s;
        zq_t                r;
        s = sub ? (49'(a) - 49'(b)) : (49'(a) + 49'(b));
        if (s[48] != s[47])
        begin
            r.flt = 1'b1;
            r.val = s[48] ? QMIN : QMAX;
        end
        else
        begin
            r.flt = 1'b0;
            r.val = s[47:0];
        end
        return r;
    endfunction

    logic [1:0]         model_reg;
    logic [46:0]        step_reg;
    logic signed [47:0] dt;
    logic [T_UN:0]      vld_reg;
    logic [T_UN:1]      zch_reg;
    logic [T_UN:0]      zinj;
    logic signed [47:0] u0_reg;
    logic signed [47:0] v0_reg;
    logic signed [47:0] het0_reg;

    zq_t w_reg, d1_reg, n2_reg, d2_reg, disc_reg, sw_reg, inner_reg;
    zq_t f1_reg, f2_reg, f3_reg, f4_reg, f5_reg, a1_reg, a2_reg;
    zq_t un_reg, vn_reg, pu_reg;
    zq_t pu_sum;
    zq_t uu_q, g16u_q, av_q, ww_q, uss_q, ussw_q, gu_q, gu2_q;
    zq_t qt_q, ri_q, of_q, um_q, vm_q, pm_q;
    zq_t ratio_q, temp_q, sq_q;

    logic signed [47:0] g16u_d, w_sq_d, w_uss_d, d1_d, het_d, uss_d, ratio_d;
    logic signed [47:0] u_f1_d, u_um_d, u_p1_d, f2_d, ussw_d, f4_d, a1_d;
    logic signed [47:0] v_vm_d, vn_d, vpass_d;
    logic signed [47:0] qq;
    logic signed [47:0] ph_sel;
    logic [48:0]        ph_d;
    logic               done_reg;
    logic signed [47:0] u_next_reg;
    logic signed [47:0] v_next_reg;
    logic               range_fault_reg;

    assign busy = 1'b0;
    assign dt   = {1'b0, step_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            model_reg <= MODEL_ZBKE;
            step_reg  <= 47'd4294967;
            vld_reg   <= '0;
            zch_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_MODEL_SELECT: model_reg <= cfg_wdata[1:0];
                    REG_STEP_SIZE:    step_reg  <= cfg_wdata;
                    default:          ;
                endcase
            end
            vld_reg  <= {vld_reg[T_UN-1:0], start};
            // fault flags ride alongside the item, OR in each op as it lands
            zch_reg  <= {zch_reg[T_UN-1:1], 1'b0} | zinj[T_UN-1:0];
            done_reg <= vld_reg[T_UN];
        end
    end

    // ---------------- arithmetic ----------------
    assign qq     = (model_reg == MODEL_ZBKE_CELL) ? het_d : K_Q;
    assign ph_sel = (model_reg == MODEL_PHASE_FIXED) ? K_W : het0_reg;
    assign pu_sum = sat_add(u_p1_d, pm_q.val, 1'b0);

    always_ff @(posedge clk)
    begin
        u0_reg    <= u_now;
        v0_reg    <= v_now;
        het0_reg  <= het_value;

        w_reg     <= sat_add(K_ONE, v0_reg, 1'b1);
        d1_reg    <= sat_add(K_EPS31, v0_reg, 1'b1);
        n2_reg    <= sat_add(K_MU, u0_reg, 1'b1);
        d2_reg    <= sat_add(K_MU, u0_reg, 1'b0);
        disc_reg  <= sat_add(ww_q.val, g16u_d, 1'b0);
        sw_reg    <= sat_add(sq_q.val, w_sq_d, 1'b1);
        inner_reg <= sat_add(qt_q.val, K_BETA, 1'b0);
        f1_reg    <= sat_add(K_PHI, uu_q.val, 1'b1);
        f2_reg    <= sat_add(f1_reg.val, u_f1_d, 1'b1);
        f3_reg    <= sat_add(f2_d, gu2_q.val, 1'b0);
        f4_reg    <= sat_add(f3_reg.val, ussw_d, 1'b0);
        f5_reg    <= sat_add(f4_d, ri_q.val, 1'b0);
        un_reg    <= sat_add(u_um_d, um_q.val, 1'b0);
        a1_reg    <= sat_add(K_2PHI, ussw_q.val, 1'b0);
        a2_reg    <= sat_add(a1_d, temp_q.val, 1'b1);
        vn_reg    <= sat_add(v_vm_d, vm_q.val, 1'b0);

        pu_reg    <= {pu_sum.flt | pm_q.flt, pu_sum.val};

        if (model_reg < MODEL_ZBKE)
        begin
            u_next_reg      <= ph_d[47:0];
            v_next_reg      <= vpass_d;
            range_fault_reg <= ph_d[48];
        end
        else
        begin
            u_next_reg      <= un_reg.val;
            v_next_reg      <= vn_d;
            range_fault_reg <= zch_reg[T_UN] | zinj[T_UN];
        end
    end

    always_comb
    begin
        zinj = '0;
        zinj[T_W]     = zinj[T_W]     | w_reg.flt | d1_reg.flt | n2_reg.flt | d2_reg.flt;
        zinj[T_UU]    = zinj[T_UU]    | uu_q.flt | g16u_q.flt | av_q.flt;
        zinj[T_WW]    = zinj[T_WW]    | ww_q.flt;
        zinj[T_DISC]  = zinj[T_DISC]  | disc_reg.flt;
        zinj[T_SQ]    = zinj[T_SQ]    | sq_q.flt;
        zinj[T_SW]    = zinj[T_SW]    | sw_reg.flt;
        zinj[T_USS]   = zinj[T_USS]   | uss_q.flt;
        zinj[T_USSW]  = zinj[T_USSW]  | ussw_q.flt | gu_q.flt;
        zinj[T_GU2]   = zinj[T_GU2]   | gu2_q.flt;
        zinj[T_RATIO] = zinj[T_RATIO] | ratio_q.flt;
        zinj[T_TEMP]  = zinj[T_TEMP]  | temp_q.flt;
        zinj[T_QT]    = zinj[T_QT]    | qt_q.flt;
        zinj[T_INNER] = zinj[T_INNER] | inner_reg.flt;
        zinj[T_RI]    = zinj[T_RI]    | ri_q.flt;
        zinj[T_F1]    = zinj[T_F1]    | f1_reg.flt;
        zinj[T_F2]    = zinj[T_F2]    | f2_reg.flt;
        zinj[T_F3]    = zinj[T_F3]    | f3_reg.flt;
        zinj[T_F4]    = zinj[T_F4]    | f4_reg.flt;
        zinj[T_F5]    = zinj[T_F5]    | f5_reg.flt;
        zinj[T_OF]    = zinj[T_OF]    | of_q.flt;
        zinj[T_UM]    = zinj[T_UM]    | um_q.flt;
        zinj[T_UN]    = zinj[T_UN]    | un_reg.flt;
        zinj[T_A1]    = zinj[T_A1]    | a1_reg.flt;
        zinj[T_A2]    = zinj[T_A2]    | a2_reg.flt;
        zinj[T_VM]    = zinj[T_VM]    | vm_q.flt;
        zinj[T_VN]    = zinj[T_VN]    | vn_reg.flt;
    end

    // ---------------- multipliers ----------------
    zbke_mul u_mul_uu   (.clk(clk), .a(u0_reg),         .b(u0_reg),       .res(uu_q));
    zbke_mul u_mul_16gu (.clk(clk), .a(K_16G),          .b(u0_reg),       .res(g16u_q));
    zbke_mul u_mul_av   (.clk(clk), .a(K_ALPHA),        .b(v0_reg),       .res(av_q));
    zbke_mul u_mul_ww   (.clk(clk), .a(w_reg.val),      .b(w_reg.val),    .res(ww_q));
    zbke_mul u_mul_uss  (.clk(clk), .a(K_INV4G),        .b(sw_reg.val),   .res(uss_q));
    zbke_mul u_mul_ussw (.clk(clk), .a(uss_q.val),      .b(w_uss_d),      .res(ussw_q));
    zbke_mul u_mul_gu   (.clk(clk), .a(K_GE2),          .b(uss_q.val),    .res(gu_q));
    zbke_mul u_mul_gu2  (.clk(clk), .a(gu_q.val),       .b(uss_d),        .res(gu2_q));
    zbke_mul u_mul_qt   (.clk(clk), .a(qq),             .b(temp_q.val),   .res(qt_q));
    zbke_mul u_mul_ri   (.clk(clk), .a(ratio_d),        .b(inner_reg.val), .res(ri_q));
    zbke_mul u_mul_of   (.clk(clk), .a(K_OOEPS1),       .b(f5_reg.val),   .res(of_q));
    zbke_mul u_mul_um   (.clk(clk), .a(dt),             .b(of_q.val),     .res(um_q));
    zbke_mul u_mul_vm   (.clk(clk), .a(dt),             .b(a2_reg.val),   .res(vm_q));
    zbke_mul u_mul_pm   (.clk(clk), .a(dt),             .b(ph_sel),       .res(pm_q));

    // ---------------- divide and root ----------------
    zbke_div  u_div_ratio (.clk(clk), .a(n2_reg.val), .b(d2_reg.val), .res(ratio_q));
    zbke_div  u_div_temp  (.clk(clk), .a(av_q.val),   .b(d1_d),       .res(temp_q));
    zbke_sqrt u_sqrt      (.clk(clk), .x(disc_reg.val), .res(sq_q));

    // ---------------- alignment ----------------
    zbke_dly #(.WIDTH(48), .DEPTH(T_WW - T_16GU)) u_d_g16u
        (.clk(clk), .din(g16u_q.val), .dout(g16u_d));
    zbke_dly #(.WIDTH(48), .DEPTH(T_SQ - T_W)) u_d_wsq
        (.clk(clk), .din(w_reg.val), .dout(w_sq_d));
    zbke_dly #(.WIDTH(48), .DEPTH(T_USS - T_W)) u_d_wuss
        (.clk(clk), .din(w_reg.val), .dout(w_uss_d));
    zbke_dly #(.WIDTH(48), .DEPTH(T_AV - T_D1)) u_d_d1
        (.clk(clk), .din(d1_reg.val), .dout(d1_d));
    zbke_dly #(.WIDTH(48), .DEPTH(T_TEMP)) u_d_het
        (.clk(clk), .din(het0_reg), .dout(het_d));
    zbke_dly #(.WIDTH(48), .DEPTH(T_GU - T_USS)) u_d_uss
        (.clk(clk), .din(uss_q.val), .dout(uss_d));
    zbke_dly #(.WIDTH(48), .DEPTH(T_INNER - T_RATIO)) u_d_ratio
        (.clk(clk), .din(ratio_q.val), .dout(ratio_d));
    zbke_dly #(.WIDTH(48), .DEPTH(T_F1)) u_d_uf1
        (.clk(clk), .din(u0_reg), .dout(u_f1_d));
    zbke_dly #(.WIDTH(48), .DEPTH(T_UM)) u_d_uum
        (.clk(clk), .din(u0_reg), .dout(u_um_d));
    zbke_dly #(.WIDTH(48), .DEPTH(T_P1)) u_d_up1
        (.clk(clk), .din(u0_reg), .dout(u_p1_d));
    zbke_dly #(.WIDTH(48), .DEPTH(T_GU2 - T_F2)) u_d_f2
        (.clk(clk), .din(f2_reg.val), .dout(f2_d));
    zbke_dly #(.WIDTH(48), .DEPTH(T_F3 - T_USSW)) u_d_ussw
        (.clk(clk), .din(ussw_q.val), .dout(ussw_d));
    zbke_dly #(.WIDTH(48), .DEPTH(T_RI - T_F4)) u_d_f4
        (.clk(clk), .din(f4_reg.val), .dout(f4_d));
    zbke_dly #(.WIDTH(48), .DEPTH(T_TEMP - T_A1)) u_d_a1
        (.clk(clk), .din(a1_reg.val), .dout(a1_d));
    zbke_dly #(.WIDTH(48), .DEPTH(T_VM)) u_d_vvm
        (.clk(clk), .din(v0_reg), .dout(v_vm_d));
    zbke_dly #(.WIDTH(48), .DEPTH(T_UN - T_VN)) u_d_vn
        (.clk(clk), .din(vn_reg.val), .dout(vn_d));
    zbke_dly #(.WIDTH(48), .DEPTH(T_UN)) u_d_vpass
        (.clk(clk), .din(v0_reg), .dout(vpass_d));
    zbke_dly #(.WIDTH(49), .DEPTH(T_UN - T_P2)) u_d_phase
        (.clk(clk), .din({pu_reg.flt, pu_reg.val}), .dout(ph_d));

    assign done        = done_reg;
    assign u_next      = u_next_reg;
    assign v_next      = v_next_reg;
    assign range_fault = range_fault_reg;

endmodule

// ----- rtl/zbke_dly.sv -----
// ----------------------------------------------------------------------------
// zbke_dly
// Fixed-depth shift line that keeps operands aligned with the datapath.
// ----------------------------------------------------------------------------
module zbke_dly #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] pipe_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        pipe_reg[0] <= din;
        for (int i = 1; i < DEPTH; i++)
        begin
            pipe_reg[i] <= pipe_reg[i-1];
        end
    end

    assign dout = pipe_reg[DEPTH-1];

endmodule

// ----- rtl/zbke_mul.sv -----
// ----------------------------------------------------------------------------
// zbke_mul
// Four-stage Q15.32 multiplier: magnitudes, 24-bit partial products,
// sum with round half away from zero, then sign and saturate.
// ----------------------------------------------------------------------------
module zbke_mul import zbke_pkg::*; (
    input  logic               clk,
    input  logic signed [47:0] a,
    input  logic signed [47:0] b,
    output zq_t                res
);

    logic [47:0] au;
    logic [47:0] bu;
    logic [47:0] ma_reg;
    logic [47:0] mb_reg;
    logic        n1_reg;
    logic [47:0] p00_reg;
    logic [47:0] p01_reg;
    logic [47:0] p10_reg;
    logic [47:0] p11_reg;
    logic        n2_reg;
    logic [95:0] rnd;
    logic [47:0] m_reg;
    logic        big_reg;
    logic        n3_reg;
    zq_t         res_reg;

    assign au = a;
    assign bu = b;

    always_comb
    begin
        rnd = {48'd0, p00_reg} + ({48'd0, p01_reg} << 24) + ({48'd0, p10_reg} << 24)
            + {p11_reg, 48'd0} + 96'd2147483648;
    end

    always_ff @(posedge clk)
    begin
        ma_reg  <= au[47] ? (48'd0 - au) : au;
        mb_reg  <= bu[47] ? (48'd0 - bu) : bu;
        n1_reg  <= au[47] ^ bu[47];

        p00_reg <= ma_reg[23:0]  * mb_reg[23:0];
        p01_reg <= ma_reg[23:0]  * mb_reg[47:24];
        p10_reg <= ma_reg[47:24] * mb_reg[23:0];
        p11_reg <= ma_reg[47:24] * mb_reg[47:24];
        n2_reg  <= n1_reg;

        m_reg   <= rnd[79:32];
        big_reg <= |rnd[95:80];
        n3_reg  <= n2_reg;

        res_reg <= sat_mag(n3_reg, {3'd0, m_reg}, big_reg);
    end

    assign res = res_reg;

endmodule

// ----- rtl/zbke_div.sv -----
// ----------------------------------------------------------------------------
// zbke_div
// Pipelined Q15.32 divider: one restoring quotient bit per stage over the
// 80-bit scaled dividend, then round half away from zero and saturate.
// ----------------------------------------------------------------------------
module zbke_div import zbke_pkg::*; (
    input  logic               clk,
    input  logic signed [47:0] a,
    input  logic signed [47:0] b,
    output zq_t                res
);

    localparam int STEPS = 80;

    logic [47:0] au;
    logic [47:0] bu;
    logic [47:0] ua_reg   [STEPS+1];
    logic [47:0] ub_reg   [STEPS+1];
    logic [47:0] r_reg    [STEPS+1];
    logic [49:0] q_reg    [STEPS+1];
    logic        big_reg  [STEPS+1];
    logic        neg_reg  [STEPS+1];
    logic        zero_reg [STEPS+1];
    logic [50:0] q1_reg;
    logic        big1_reg;
    logic        neg1_reg;
    logic        zero1_reg;
    zq_t         res_reg;

    assign au = a;
    assign bu = b;

    always_ff @(posedge clk)
    begin
        logic [79:0] nn;
        logic [48:0] rr;
        logic        ge;
        ua_reg[0]   <= au[47] ? (48'd0 - au) : au;
        ub_reg[0]   <= bu[47] ? (48'd0 - bu) : bu;
        r_reg[0]    <= '0;
        q_reg[0]    <= '0;
        big_reg[0]  <= 1'b0;
        neg_reg[0]  <= au[47] ^ bu[47];
        zero_reg[0] <= (bu == 48'd0);

        // one quotient bit per stage, most significant first
        for (int k = 0; k < STEPS; k++)
        begin
            nn = {ua_reg[k], 32'd0};
            rr = {r_reg[k], nn[STEPS-1-k]};
            ge = (rr >= {1'b0, ub_reg[k]});
            r_reg[k+1]    <= ge ? 48'(rr - {1'b0, ub_reg[k]}) : rr[47:0];
            q_reg[k+1]    <= {q_reg[k][48:0], ge};
            big_reg[k+1]  <= big_reg[k] | (ge && ((STEPS - 1 - k) >= 50));
            ua_reg[k+1]   <= ua_reg[k];
            ub_reg[k+1]   <= ub_reg[k];
            neg_reg[k+1]  <= neg_reg[k];
            zero_reg[k+1] <= zero_reg[k];
        end

        q1_reg    <= {1'b0, q_reg[STEPS]}
                   + (({r_reg[STEPS], 1'b0} >= {1'b0, ub_reg[STEPS]}) ? 51'd1 : 51'd0);
        big1_reg  <= big_reg[STEPS];
        neg1_reg  <= neg_reg[STEPS];
        zero1_reg <= zero_reg[STEPS];

        if (zero1_reg)
        begin
            res_reg <= {1'b1, 48'd0};
        end
        else
        begin
            res_reg <= sat_mag(neg1_reg, q1_reg, big1_reg);
        end
    end

    assign res = res_reg;

endmodule

// ----- rtl/zbke_sqrt.sv -----
// ----------------------------------------------------------------------------
// zbke_sqrt
// Pipelined Q15.32 square root: clamp negative input, then one root bit per
// stage (two radicand bits brought down each time), result is the floor.
// ----------------------------------------------------------------------------
module zbke_sqrt import zbke_pkg::*; (
    input  logic               clk,
    input  logic signed [47:0] x,
    output zq_t                res
);

    localparam int STEPS = 40;

    logic [47:0] rad_reg  [STEPS+1];
    logic [42:0] rem_reg  [STEPS+1];
    logic [39:0] root_reg [STEPS+1];
    logic        flt_reg  [STEPS+1];

    always_ff @(posedge clk)
    begin
        logic [79:0] nn;
        logic [42:0] rr;
        logic [42:0] tt;
        rad_reg[0]  <= x[47] ? 48'd0 : x;
        flt_reg[0]  <= x[47];
        rem_reg[0]  <= '0;
        root_reg[0] <= '0;

        for (int k = 0; k < STEPS; k++)
        begin
            nn = {rad_reg[k], 32'd0};
            rr = {rem_reg[k][40:0], nn[2*(STEPS-1-k) +: 2]};
            tt = {1'b0, root_reg[k], 2'b01};
            if (rr >= tt)
            begin
                rem_reg[k+1]  <= rr - tt;
                root_reg[k+1] <= {root_reg[k][38:0], 1'b1};
            end
            else
            begin
                rem_reg[k+1]  <= rr;
                root_reg[k+1] <= {root_reg[k][38:0], 1'b0};
            end
            rad_reg[k+1] <= rad_reg[k];
            flt_reg[k+1] <= flt_reg[k];
        end
    end

    assign res.flt = flt_reg[STEPS];
    assign res.val = {8'd0, root_reg[STEPS]};

endmodule
